### rtl/csm_pkg.sv
`default_nettype none

package csm_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned AREA_W  = 32;
  localparam int unsigned COEF_W  = 48;
  localparam int unsigned ROW_W   = 11;
  localparam int unsigned NUM_W   = 65;
  localparam int unsigned DEN_W   = 33;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned MAXP_W  = 16;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam logic [31:0] CONDUCTANCE_RST  = 32'h0001_0000;
  localparam logic        REG_CONDUCTANCE  = 1'b0;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_ZERO = 2'd1,
    STS_MANY = 2'd2
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0]  node_position;
    logic [AREA_W-1:0] node_area;
    logic              last_node;
  } node_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row_index;
    logic signed [COEF_W-1:0] sub_entry;
    logic signed [COEF_W-1:0] diag_entry;
    logic signed [COEF_W-1:0] super_entry;
    logic                     last_row;
    logic [1:0]               status;
  } row_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_COEF,
    ST_ROW0,
    ST_ROW1,
    ST_SINGLE
  } state_t;

  typedef struct packed {
    logic capture;
    logic store_first;
    logic prep;
    logic mul;
    logic div_start;
    logic coef;
    logic load_row0;
    logic load_row1;
    logic load_single;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last_node;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

### rtl/csm_div.sv
`default_nettype none

module csm_div
  import csm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic [COEF_W-1:0]      mag
);

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [COEF_W-1:0] q_r;
  logic              ovf_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [DEN_W-1:0]  rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    diff    = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= STEP_W'(NUM_W - 1);
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[COEF_W-2:0], ge};
      ovf_r <= ovf_r | q_r[COEF_W-1];
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign mag  = (ovf_r || q_r[COEF_W-1]) ? COEF_MAX : q_r;

  a_div_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r == '0) && !start |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

endmodule

`default_nettype wire

### rtl/csm_dp.sv
`default_nettype none

module csm_dp
  import csm_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire node_beat_t  in_data,
  input  wire logic [31:0] conductance,
  output row_beat_t        out_data
);

  localparam logic [ROW_W-1:0]  ROW_LIMIT = (MAX_ELEMENTS < 2047) ?
                                            ROW_W'(MAX_ELEMENTS) : ROW_W'(2047);
  localparam logic [MAXP_W-1:0] MAX_EL    = MAXP_W'(MAX_ELEMENTS);

  logic [POS_W-1:0]         cur_pos_r;
  logic [AREA_W-1:0]        cur_area_r;
  logic                     cur_last_r;
  logic [POS_W-1:0]         prev_pos_r;
  logic [AREA_W-1:0]        prev_area_r;
  logic signed [COEF_W-1:0] prev_coef_r;
  logic [ROW_W-1:0]         row_cnt_r;
  logic                     have_prev_r;
  logic [AREA_W:0]          asum_r;
  logic [POS_W-1:0]         dmag_r;
  logic                     neg_r;
  logic                     zero_r;
  logic                     many_r;
  logic [63:0]              prod_r;
  logic signed [COEF_W-1:0] coef_r;
  row_beat_t                out_r;

  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_done;
  logic [COEF_W-1:0]        div_mag;
  logic signed [COEF_W-1:0] coef_nxt;
  logic signed [COEF_W:0]   diag_wide;
  logic signed [COEF_W-1:0] diag0;
  logic [1:0]               row_status;

  assign div_num = {1'b0, prod_r} +
                   {1'b0, (asum_r[AREA_W] ? conductance : 32'd0), 32'd0};
  assign div_den = {dmag_r, 1'b0};

  csm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .mag   (div_mag)
  );

  always_comb begin
    if (zero_r) begin
      coef_nxt = COEF_MAX;
    end else if (neg_r) begin
      coef_nxt = -$signed(div_mag);
    end else begin
      coef_nxt = $signed(div_mag);
    end
    diag_wide = -{prev_coef_r[COEF_W-1], prev_coef_r} - {coef_r[COEF_W-1], coef_r};
    if (diag_wide[COEF_W] != diag_wide[COEF_W-1]) begin
      diag0 = diag_wide[COEF_W] ? COEF_MIN : COEF_MAX;
    end else begin
      diag0 = diag_wide[COEF_W-1:0];
    end
    if (many_r) begin
      row_status = STS_MANY;
    end else if (zero_r) begin
      row_status = STS_ZERO;
    end else begin
      row_status = STS_OK;
    end
  end

  // node capture and element setup
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_pos_r  <= in_data.node_position;
      cur_area_r <= in_data.node_area;
      cur_last_r <= in_data.last_node;
    end
    if (cmd.prep) begin
      asum_r <= {1'b0, prev_area_r} + {1'b0, cur_area_r};
      zero_r <= (cur_pos_r == prev_pos_r);
      neg_r  <= (cur_pos_r < prev_pos_r);
      dmag_r <= (cur_pos_r < prev_pos_r) ? (prev_pos_r - cur_pos_r)
                                         : (cur_pos_r - prev_pos_r);
      many_r <= ({{(MAXP_W-ROW_W){1'b0}}, row_cnt_r} >= MAX_EL);
    end
    if (cmd.mul) begin
      prod_r <= 64'(conductance) * 64'(asum_r[AREA_W-1:0]);
    end
    if (cmd.coef) begin
      coef_r <= coef_nxt;
    end
  end

  // cable state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      prev_pos_r  <= '0;
      prev_area_r <= '0;
      prev_coef_r <= '0;
      row_cnt_r   <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.store_first) begin
      prev_pos_r  <= cur_pos_r;
      prev_area_r <= cur_area_r;
      prev_coef_r <= '0;
      row_cnt_r   <= '0;
      have_prev_r <= 1'b1;
    end else if (cmd.load_row0) begin
      prev_pos_r  <= cur_pos_r;
      prev_area_r <= cur_area_r;
      prev_coef_r <= coef_r;
      if (row_cnt_r < ROW_LIMIT) begin
        row_cnt_r <= row_cnt_r + ROW_W'(1);
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (cmd.load_row0) begin
      out_r.row_index   <= row_cnt_r;
      out_r.sub_entry   <= prev_coef_r;
      out_r.diag_entry  <= diag0;
      out_r.super_entry <= coef_r;
      out_r.last_row    <= 1'b0;
      out_r.status      <= row_status;
    end else if (cmd.load_row1) begin
      out_r.row_index   <= row_cnt_r;
      out_r.sub_entry   <= coef_r;
      out_r.diag_entry  <= -coef_r;
      out_r.super_entry <= '0;
      out_r.last_row    <= 1'b1;
      out_r.status      <= row_status;
    end else if (cmd.load_single) begin
      out_r.row_index   <= '0;
      out_r.sub_entry   <= '0;
      out_r.diag_entry  <= '0;
      out_r.super_entry <= '0;
      out_r.last_row    <= 1'b1;
      out_r.status      <= STS_OK;
    end
  end

  assign out_data       = out_r;
  assign stat.have_prev = have_prev_r;
  assign stat.last_node = cur_last_r;
  assign stat.div_done  = div_done;

  a_clear_resets_cable: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (row_cnt_r == '0) && !have_prev_r && (prev_coef_r == '0))
    else $error("cable state not cleared after final row");

endmodule

`default_nettype wire

### rtl/csm_ctrl.sv
`default_nettype none

module csm_ctrl
  import csm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.have_prev) begin
          if (stat.last_node) begin
            state_nxt = ST_SINGLE;
          end else begin
            cmd.store_first = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_COEF;
        end
      end
      ST_COEF: begin
        cmd.coef  = 1'b1;
        state_nxt = ST_ROW0;
      end
      ST_ROW0: begin
        if (out_free) begin
          cmd.load_row0 = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = stat.last_node ? ST_ROW1 : ST_IDLE;
        end
      end
      ST_ROW1: begin
        if (out_free) begin
          cmd.load_row1 = 1'b1;
          cmd.clear     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          cmd.load_single = 1'b1;
          cmd.clear       = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_row0 || cmd.load_row1 || cmd.load_single) |-> (!out_valid_r || !out_stall))
    else $error("output beat overwritten while still pending");

  a_coef_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COEF) |-> $past(stat.div_done))
    else $error("coefficient taken before divider finished");

  a_row1_after_row0: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_ROW1) |-> $past(cmd.load_row0))
    else $error("final row not preceded by element row");

endmodule

`default_nettype wire

### rtl/cable_stiffness_matrix_rows_unit.sv
// channel   dir   beat / fields                                 handshake
// in_       in    node_position, node_area, last_node           in_valid / in_stall
// out_      out   row_index, sub/diag/super_entry, last_row,    out_valid / out_stall
//                 status
// cfg_      in    conductance at byte address 0                 apb, pready always high
//
// one node at a time: a node closing an element goes through decide, multiply, the
// 65-step radix-2 divider and the coefficient before its row; the last node adds
// the final row; a first node is only stored, a single-node cable gives one row
// a result waits in the output register while the next node is taken
// out_stall holds a row in the output register; the next row waits for it
// rst_n is synchronous; conductance returns to 1.0 and the cable state clears
`default_nettype none

module cable_stiffness_matrix_rows_unit
  import csm_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire node_beat_t  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output row_beat_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [31:0] conductance_r;
  cmd_t        cmd;
  stat_t       stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conductance_r <= CONDUCTANCE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == REG_CONDUCTANCE)) begin
      conductance_r <= cfg_pwdata;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CONDUCTANCE) ? conductance_r : 32'd0;

  csm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  csm_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .conductance (conductance_r),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
